[sv/idf_pkg.sv]
// idf_pkg: shared types and constants for the IPTC dataset deframer.
// Used by idf_step, iptc_dataset_deframer_core, idf_checker and the testbench; no dependencies.
package idf_pkg;

    localparam logic [7:0]  MARKER   = 8'h1C;
    localparam int unsigned SOS_MAX  = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_OVERRUN = 2'd2,
        KIND_BAD_SOS = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_buffer;
        logic [31:0] buffer_length;
    } in_beat_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  record_number;
        logic [7:0]  dataset_number;
        logic [7:0]  payload_byte;
        logic [31:0] dataset_length;
        logic        last_of_dataset;
    } out_beat_t;

endpackage

[sv/idf_step.sv]
// idf_step: parser state and the one-byte step logic of the deframer.
// Depends on idf_pkg. State advances on every fire; result is combinational.
module idf_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  idf_pkg::in_beat_t item,
    output logic              rslt_ok,
    output idf_pkg::out_beat_t rslt
);

    typedef enum logic [2:0] {
        PH_SCAN, PH_RECORD, PH_DATASET, PH_LEN_HI,
        PH_LEN_LO, PH_EXT, PH_PAYLOAD, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next, phase_e;
    logic [31:0] pos_reg, pos_next, pos_e;
    logic [31:0] blen_reg, blen_next, blen_e;
    logic [7:0]  rec_reg, rec_next, rec_e;
    logic [7:0]  ds_reg, ds_next, ds_e;
    logic [31:0] acc_reg, acc_next, acc_e;
    logic [2:0]  left_reg, left_next, left_e;
    logic [7:0]  flb_reg, flb_next, flb_e;
    logic [31:0] bleft_reg, bleft_next, bleft_e;

    logic [32:0] pos_inc;
    logic        last_in_buf;
    logic        scan_ok;
    logic        fin_go;
    logic        fin_beyond;
    logic        bad_sos;
    logic [31:0] fin_size;
    logic [33:0] fin_end;
    logic        fin_fits;
    logic [14:0] sos;
    logic [31:0] acc_sh;
    logic [2:0]  left_dec;
    logic        pay_last;
    logic [7:0]  b;

    always_comb
    begin
        b = item.data_byte;
        // a first byte restarts the parser before the byte is looked at
        if (item.first_of_buffer)
        begin
            phase_e = PH_SCAN;
            pos_e   = '0;
            blen_e  = item.buffer_length;
            rec_e   = '0;
            ds_e    = '0;
            acc_e   = '0;
            left_e  = '0;
            flb_e   = '0;
            bleft_e = '0;
        end
        else
        begin
            phase_e = phase_reg;
            pos_e   = pos_reg;
            blen_e  = blen_reg;
            rec_e   = rec_reg;
            ds_e    = ds_reg;
            acc_e   = acc_reg;
            left_e  = left_reg;
            flb_e   = flb_reg;
            bleft_e = bleft_reg;
        end

        pos_inc     = {1'b0, pos_e} + 33'd1;
        last_in_buf = pos_inc >= {1'b0, blen_e};
        scan_ok     = ({1'b0, pos_e} + 33'd3) < {1'b0, blen_e};
        sos         = {flb_e[6:0], b};
        left_dec    = left_e - 3'd1;
        pay_last    = bleft_e <= 32'd1;

        // zero-fill the length bytes cut off by the buffer end
        case (left_dec)
            3'd0:    acc_sh = {acc_e[23:0], b};
            3'd1:    acc_sh = {acc_e[15:0], b, 8'h00};
            3'd2:    acc_sh = {acc_e[7:0], b, 16'h0000};
            3'd3:    acc_sh = {b, 24'h000000};
            default: acc_sh = '0;
        endcase

        phase_next = phase_e;
        pos_next   = (pos_e == '1) ? pos_e : pos_inc[31:0];
        blen_next  = blen_e;
        rec_next   = rec_e;
        ds_next    = ds_e;
        acc_next   = acc_e;
        left_next  = left_e;
        flb_next   = flb_e;
        bleft_next = bleft_e;

        fin_go     = 1'b0;
        fin_beyond = 1'b0;
        fin_size   = '0;
        bad_sos    = 1'b0;

        rslt_ok              = 1'b0;
        rslt.kind            = idf_pkg::KIND_PAYLOAD;
        rslt.record_number   = rec_e;
        rslt.dataset_number  = ds_e;
        rslt.payload_byte    = '0;
        rslt.dataset_length  = '0;
        rslt.last_of_dataset = 1'b0;

        case (phase_e)
            PH_SCAN:
            begin
                if (scan_ok && b == idf_pkg::MARKER)
                    phase_next = PH_RECORD;
            end
            PH_RECORD:
            begin
                rec_next   = b;
                phase_next = PH_DATASET;
            end
            PH_DATASET:
            begin
                ds_next    = b;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                flb_next = b;
                if (!last_in_buf)
                    phase_next = PH_LEN_LO;
                else if (b[7])
                begin
                    if (b[6:0] != 7'd0)
                        bad_sos = 1'b1;
                    else
                    begin
                        fin_go     = 1'b1;
                        fin_beyond = 1'b1;
                    end
                end
                else
                begin
                    fin_go     = 1'b1;
                    fin_beyond = 1'b1;
                    fin_size   = {16'h0000, b, 8'h00};
                end
            end
            PH_LEN_LO:
            begin
                if (flb_e[7])
                begin
                    if ({17'd0, sos} > 32'(idf_pkg::SOS_MAX))
                        bad_sos = 1'b1;
                    else if (sos == 15'd0)
                        fin_go = 1'b1;
                    else if (last_in_buf)
                    begin
                        fin_go     = 1'b1;
                        fin_beyond = 1'b1;
                    end
                    else
                    begin
                        acc_next   = '0;
                        left_next  = sos[2:0];
                        phase_next = PH_EXT;
                    end
                end
                else
                begin
                    fin_go   = 1'b1;
                    fin_size = {16'h0000, flb_e, b};
                end
            end
            PH_EXT:
            begin
                acc_next  = {acc_e[23:0], b};
                left_next = left_dec;
                if (left_dec == 3'd0)
                begin
                    fin_go   = 1'b1;
                    fin_size = {acc_e[23:0], b};
                end
                else if (last_in_buf)
                begin
                    fin_go     = 1'b1;
                    fin_beyond = 1'b1;
                    fin_size   = acc_sh;
                end
            end
            PH_PAYLOAD:
            begin
                rslt_ok              = 1'b1;
                rslt.kind            = idf_pkg::KIND_PAYLOAD;
                rslt.payload_byte    = b;
                rslt.dataset_length  = acc_e;
                rslt.last_of_dataset = pay_last;
                bleft_next           = pay_last ? 32'd0 : bleft_e - 32'd1;
                if (pay_last)
                    phase_next = PH_SCAN;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // header complete: payload would start at the next position
        fin_end  = {1'b0, pos_inc} + {2'b00, fin_size};
        fin_fits = !fin_beyond && (fin_end <= {2'b00, blen_e});

        if (bad_sos)
        begin
            phase_next           = PH_DONE;
            acc_next             = '0;
            rslt_ok              = 1'b1;
            rslt.kind            = idf_pkg::KIND_BAD_SOS;
            rslt.last_of_dataset = 1'b1;
        end
        else if (fin_go)
        begin
            acc_next = fin_size;
            if (fin_fits)
            begin
                if (fin_size == '0)
                begin
                    phase_next           = PH_SCAN;
                    rslt_ok              = 1'b1;
                    rslt.kind            = idf_pkg::KIND_EMPTY;
                    rslt.last_of_dataset = 1'b1;
                end
                else
                begin
                    bleft_next = fin_size;
                    phase_next = PH_PAYLOAD;
                end
            end
            else
            begin
                phase_next           = PH_DONE;
                rslt_ok              = 1'b1;
                rslt.kind            = idf_pkg::KIND_OVERRUN;
                rslt.dataset_length  = fin_size;
                rslt.last_of_dataset = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SCAN;
            pos_reg   <= '0;
            blen_reg  <= '0;
            rec_reg   <= '0;
            ds_reg    <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
            flb_reg   <= '0;
            bleft_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            blen_reg  <= blen_next;
            rec_reg   <= rec_next;
            ds_reg    <= ds_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            flb_reg   <= flb_next;
            bleft_reg <= bleft_next;
        end
    end

endmodule

[sv/iptc_dataset_deframer_core.sv]
// iptc_dataset_deframer_core: top level of the IPTC IIM dataset deframer.
// Depends on idf_pkg and idf_step.
//
// Takes an IPTC IIM block one byte per beat on the data channel and gives
// at most one result beat per byte on the rslt channel: payload bytes tagged
// with record and dataset, an empty-dataset marker, an overrun report or a
// bad size-of-size stop. A beat with first_of_buffer set restarts parsing
// and samples buffer_length. Throughput is one byte per clock while the
// result channel does not stall: the byte sits in an input register, the
// parser state advances in the cycle it moves on, and the result lands in
// an output register, so a result that leaves in the same cycle never
// holds up the next byte. A stalled result lets a byte into the input
// register only while it is empty, then data_stall rises. The rate is set
// by the state update of the header/payload sequencer, whose longest path
// is the 34-bit end-of-dataset add and compare against the buffer length.
// No clearing pass: the parser is ready right out of reset.
module iptc_dataset_deframer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               data_valid,
    output logic               data_stall,
    input  idf_pkg::in_beat_t  data_beat,
    output logic               rslt_valid,
    input  logic               rslt_stall,
    output idf_pkg::out_beat_t rslt_beat
);

    logic               in_valid_reg, in_valid_next;
    idf_pkg::in_beat_t  in_beat_reg;
    logic               out_valid_reg, out_valid_next;
    idf_pkg::out_beat_t out_beat_reg;

    logic               out_free;
    logic               step_fire;
    logic               step_ok;
    idf_pkg::out_beat_t step_rslt;

    // output slot is free when empty or being drained this cycle
    assign out_free   = !out_valid_reg || !rslt_stall;
    assign step_fire  = in_valid_reg && out_free;
    assign data_stall = in_valid_reg && !out_free;

    assign in_valid_next  = (data_valid && !data_stall) ? 1'b1 :
                            (step_fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_free ? (step_fire && step_ok) : out_valid_reg;

    idf_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (step_fire),
        .item    (in_beat_reg),
        .rslt_ok (step_ok),
        .rslt    (step_rslt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (data_valid && !data_stall)
            in_beat_reg <= data_beat;
        if (out_free)
            out_beat_reg <= step_rslt;
    end

    assign rslt_valid = out_valid_reg;
    assign rslt_beat  = out_beat_reg;

endmodule

[sv/idf_checker.sv]
// idf_checker: port-level assertions for iptc_dataset_deframer_core.
// Depends on idf_pkg; bound to the top level at the end of this file.
module idf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rslt_valid,
    input logic               rslt_stall,
    input idf_pkg::out_beat_t rslt_beat
);

    // a held result beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && rslt_stall |=> rslt_valid && $stable(rslt_beat))
        else $error("result beat changed while stalled");

    // every non-payload report closes its dataset
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && rslt_beat.kind != idf_pkg::KIND_PAYLOAD
        |-> rslt_beat.last_of_dataset)
        else $error("report without last_of_dataset");

    // only payload beats carry a data byte
    a_zero_pay: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && rslt_beat.kind != idf_pkg::KIND_PAYLOAD
        |-> rslt_beat.payload_byte == 8'h00)
        else $error("nonzero payload byte on report");

    // empty and bad size-of-size reports carry zero length
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && (rslt_beat.kind == idf_pkg::KIND_EMPTY ||
                       rslt_beat.kind == idf_pkg::KIND_BAD_SOS)
        |-> rslt_beat.dataset_length == 32'd0)
        else $error("nonzero length on empty or bad size report");

    // a payload beat never reports a zero-length dataset
    a_pay_len: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && rslt_beat.kind == idf_pkg::KIND_PAYLOAD
        |-> rslt_beat.dataset_length != 32'd0)
        else $error("payload beat of zero-length dataset");

endmodule

bind iptc_dataset_deframer_core idf_checker u_idf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rslt_valid (rslt_valid),
    .rslt_stall (rslt_stall),
    .rslt_beat  (rslt_beat)
);

[tb/tb_iptc_dataset_deframer_core.sv]
// tb_iptc_dataset_deframer_core: self-checking testbench for the IPTC dataset deframer.
// Depends on idf_pkg and iptc_dataset_deframer_core; predicts every result beat
// from its own copy of the parser state and checks them in order.
module tb_iptc_dataset_deframer_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    // parser phases, mirrored locally for prediction
    typedef enum logic [2:0] {
        ST_SCAN,
        ST_RECORD,
        ST_DATASET,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_EXT_LEN,
        ST_PAYLOAD,
        ST_DONE
    } parse_st_t;

    // one pending input beat; drain_first holds it back until no result is due
    typedef struct {
        idf_pkg::in_beat_t beat;
        bit                drain_first;
    } feed_item_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               data_valid = 1'b0;
    logic               data_stall;
    idf_pkg::in_beat_t  data_beat  = '0;
    logic               rslt_valid;
    logic               rslt_stall = 1'b0;
    idf_pkg::out_beat_t rslt_beat;

    feed_item_t          byte_feed[$];
    idf_pkg::out_beat_t  due_results[$];
    logic [7:0]          frame_q[$];

    // predicted parser state
    parse_st_t   st       = ST_SCAN;
    logic [31:0] pos      = '0;
    logic [31:0] blk_len  = '0;
    logic [7:0]  rec      = '0;
    logic [7:0]  dset     = '0;
    logic [31:0] len_acc  = '0;
    logic [2:0]  ext_left = '0;
    logic [7:0]  len_hi   = '0;
    logic [31:0] pay_left = '0;

    // bookkeeping
    int unsigned        n_bytes     = 0;
    int unsigned        n_predicted = 0;
    int unsigned        n_checked   = 0;
    int unsigned        mismatches  = 0;
    int unsigned        kind_seen[4];
    int unsigned        feed_gap    = 0;
    int unsigned        stall_left  = 0;
    int unsigned        idle_cycles = 0;
    bit                 burst_ok    = 1'b0;
    feed_item_t         next_item;
    idf_pkg::out_beat_t want_beat;

    always #5 clk = ~clk;

    iptc_dataset_deframer_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_beat  (data_beat),
        .rslt_valid (rslt_valid),
        .rslt_stall (rslt_stall),
        .rslt_beat  (rslt_beat)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void note_result(idf_pkg::kind_t k, logic [7:0] pay,
                                        logic [31:0] len, logic last);
        idf_pkg::out_beat_t r;
        r.kind            = k;
        r.record_number   = rec;
        r.dataset_number  = dset;
        r.payload_byte    = pay;
        r.dataset_length  = len;
        r.last_of_dataset = last;
        due_results.insert(due_results.size(), r);
        n_predicted++;
    endfunction

    // Header complete: payload would begin at byte 'start' and span 'size' bytes.
    function automatic void close_header(logic [32:0] start, logic [31:0] size);
        len_acc = size;
        if (34'(start) + 34'(size) <= 34'(blk_len))
        begin
            if (size == 0)
            begin
                st = ST_SCAN;
                note_result(idf_pkg::KIND_EMPTY, 8'd0, 32'd0, 1'b1);
            end
            else
            begin
                pay_left = size;
                st       = ST_PAYLOAD;
            end
        end
        else
        begin
            // runs past the buffer end: report and ignore the rest
            st = ST_DONE;
            note_result(idf_pkg::KIND_OVERRUN, 8'd0, size, 1'b1);
        end
    endfunction

    function automatic void reject_size();
        st      = ST_DONE;
        len_acc = '0;
        note_result(idf_pkg::KIND_BAD_SOS, 8'd0, 32'd0, 1'b1);
    endfunction

    function automatic void parse_byte(idf_pkg::in_beat_t in);
        logic [7:0]  b;
        logic [32:0] here_next;
        logic [32:0] past_end;
        logic        last_byte;
        logic        fin;
        logic [15:0] lenf;
        logic [14:0] sos;
        b = in.data_byte;
        if (in.first_of_buffer)
        begin
            st       = ST_SCAN;
            pos      = '0;
            rec      = '0;
            dset     = '0;
            len_acc  = '0;
            ext_left = '0;
            len_hi   = '0;
            pay_left = '0;
            blk_len  = in.buffer_length;
        end
        here_next = 33'(pos) + 33'd1;
        past_end  = 33'(blk_len) + 33'd1;
        last_byte = (here_next >= 33'(blk_len));

        case (st)
            ST_SCAN:
            begin
                // a marker counts only with at least four bytes left
                if (33'(pos) + 33'd3 < 33'(blk_len) && b == idf_pkg::MARKER)
                    st = ST_RECORD;
            end
            ST_RECORD:
            begin
                rec = b;
                st  = ST_DATASET;
            end
            ST_DATASET:
            begin
                dset = b;
                st   = ST_LEN_HI;
            end
            ST_LEN_HI:
            begin
                len_hi = b;
                if (!last_byte)
                    st = ST_LEN_LO;
                else if (b[7])
                begin
                    // buffer ends mid-header; missing bytes read as zero
                    if (b[6:0] != 0)
                        reject_size();
                    else
                        close_header(past_end, 32'd0);
                end
                else
                    close_header(past_end, {16'd0, b, 8'd0});
            end
            ST_LEN_LO:
            begin
                lenf = {len_hi, b};
                if (len_hi[7])
                begin
                    sos = lenf[14:0];
                    if (sos > idf_pkg::SOS_MAX)
                        reject_size();
                    else if (sos == 0)
                        close_header(here_next, 32'd0);
                    else if (last_byte)
                        close_header(past_end, 32'd0);
                    else
                    begin
                        len_acc  = '0;
                        ext_left = sos[2:0];
                        st       = ST_EXT_LEN;
                    end
                end
                else
                    close_header(here_next, {16'd0, lenf});
            end
            ST_EXT_LEN:
            begin
                len_acc  = {len_acc[23:0], b};
                ext_left = ext_left - 3'd1;
                if (ext_left == 0)
                    close_header(here_next, len_acc);
                else if (last_byte)
                    close_header(past_end, len_acc << (8 * ext_left));
            end
            ST_PAYLOAD:
            begin
                fin = (pay_left <= 32'd1);
                note_result(idf_pkg::KIND_PAYLOAD, b, len_acc, fin);
                if (fin)
                begin
                    pay_left = '0;
                    st       = ST_SCAN;
                end
                else
                    pay_left = pay_left - 32'd1;
            end
            default:
                st = ST_DONE;
        endcase

        if (pos != '1)
            pos = pos + 32'd1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    function automatic void send_frame(logic [31:0] blen, bit drain);
        feed_item_t item;
        foreach (frame_q[i])
        begin
            item.beat.data_byte       = frame_q[i];
            item.beat.first_of_buffer = (i == 0);
            item.beat.buffer_length   = (i == 0) ? blen : 32'($urandom);
            item.drain_first          = drain && (i == 0);
            byte_feed.insert(byte_feed.size(), item);
        end
    endfunction

    function automatic void add_byte(logic [7:0] v);
        frame_q.insert(frame_q.size(), v);
    endfunction

    function automatic void add_dataset();
        int unsigned form;
        int unsigned size_of_size;
        int unsigned body;
        logic [31:0] declared;
        add_byte(idf_pkg::MARKER);
        add_byte(8'($urandom));
        add_byte(8'($urandom));
        form     = $urandom_range(0, 9);
        body     = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
        declared = body;
        if (form == 9)
        begin
            // size-of-size out of range, in the high byte or above four in the low byte
            if ($urandom_range(0, 1) == 1)
            begin
                add_byte(8'h80 | 8'($urandom_range(1, 127)));
                add_byte(8'($urandom));
            end
            else
            begin
                add_byte(8'h80);
                add_byte(8'($urandom_range(5, 255)));
            end
            return;
        end
        // long dataset, header only; mostly overruns
        if ($urandom_range(0, 5) == 0)
        begin
            declared = $urandom;
            body     = 0;
        end
        if (form < 6)
        begin
            declared = {17'd0, declared[14:0]};
            add_byte(declared[15:8]);
            add_byte(declared[7:0]);
        end
        else
        begin
            size_of_size = $urandom_range(0, 4);
            for (int k = size_of_size; k < 4; k++)
                declared[8*k +: 8] = 8'd0;
            add_byte(8'h80);
            add_byte(8'(size_of_size));
            for (int k = size_of_size; k > 0; k--)
                add_byte(declared[8*(k-1) +: 8]);
        end
        repeat (body) add_byte(8'($urandom));
    endfunction

    // Returns how many bytes of the new buffer lie inside its declared length.
    function automatic int unsigned add_buffer(bit drain);
        int unsigned pick;
        int unsigned used;
        logic [31:0] blen;
        frame_q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            // noise, with markers sprinkled in
            repeat ($urandom_range(1, 12))
                add_byte(($urandom_range(0, 3) == 0) ? idf_pkg::MARKER : 8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
                add_dataset();
            end
        end
        pick = $urandom_range(0, 19);
        if (pick < 13)
            blen = frame_q.size();
        else if (pick < 16)
            blen = $urandom_range(1, frame_q.size());       // cut short
        else if (pick < 18)
            blen = frame_q.size() + $urandom_range(1, 8);   // longer than sent
        else if (pick == 18)
            blen = $urandom;
        else
            blen = ($urandom_range(0, 1) == 1) ? '1 : '0;
        used = (blen < frame_q.size()) ? blen : frame_q.size();
        // trailing bytes past the end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
        send_frame(blen, drain);
        return used;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: predicts each accepted beat, then offers the next one.
    // A stalled beat is held as is; gaps come in random bursts.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            data_valid <= 1'b0;
        else
        begin
            if (data_valid && !data_stall)
            begin
                parse_byte(data_beat);
                n_bytes++;
            end
            if (!data_valid || !data_stall)
            begin
                if (feed_gap != 0)
                begin
                    feed_gap--;
                    data_valid <= 1'b0;
                end
                else if (byte_feed.size() == 0 ||
                         (byte_feed[0].drain_first && n_predicted != n_checked))
                    data_valid <= 1'b0;   // nothing left, or draining results first
                else if (burst_ok && $urandom_range(0, 11) == 0)
                begin
                    feed_gap = $urandom_range(0, 12);
                    data_valid <= 1'b0;
                end
                else
                begin
                    next_item = byte_feed.pop_front();
                    data_beat  <= next_item.beat;
                    data_valid <= 1'b1;
                end
            end
            // bursts off for one stretch in four, and near the end of the feed
            burst_ok <= (byte_feed.size() > 120) && ((byte_feed.size() / 100) % 4 != 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result beat with the oldest expectation and
    // drives random stall bursts.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            rslt_stall <= 1'b0;
        else
        begin
            if (rslt_valid && !rslt_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result beat with none due: expected nothing, actual %p",
                             $time, rslt_beat);
                    mismatches++;
                end
                else
                begin
                    want_beat = due_results.pop_front();
                    check_field("kind", 32'(want_beat.kind), 32'(rslt_beat.kind));
                    check_field("record_number", 32'(want_beat.record_number),
                                32'(rslt_beat.record_number));
                    check_field("dataset_number", 32'(want_beat.dataset_number),
                                32'(rslt_beat.dataset_number));
                    check_field("payload_byte", 32'(want_beat.payload_byte),
                                32'(rslt_beat.payload_byte));
                    check_field("dataset_length", want_beat.dataset_length,
                                rslt_beat.dataset_length);
                    check_field("last_of_dataset", 32'(want_beat.last_of_dataset),
                                32'(rslt_beat.last_of_dataset));
                    kind_seen[want_beat.kind]++;
                    n_checked <= n_checked + 1;
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rslt_stall <= 1'b1;
            end
            else if (burst_ok && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                rslt_stall <= 1'b1;
            end
            else
                rslt_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed buffers, random buffers, reset, then wait for the
    // last result with the watchdog running.
    // ------------------------------------------------------------------
    initial
    begin
        feed_item_t  lone;
        int unsigned random_items;
        int unsigned buffers;
        int unsigned settle;

        // no buffer started yet: a marker here is ignored
        lone.beat.data_byte       = idf_pkg::MARKER;
        lone.beat.first_of_buffer = 1'b0;
        lone.beat.buffer_length   = 32'hFFFF_FFFF;
        lone.drain_first          = 1'b0;
        byte_feed.insert(byte_feed.size(), lone);

        // standard length, two payload bytes at both extremes
        frame_q = {idf_pkg::MARKER, 8'h02, 8'h05, 8'h00, 8'h02, 8'h00, 8'hFF};
        send_frame(32'd7, 1'b0);
        // zero-length dataset
        frame_q = {idf_pkg::MARKER, 8'h01, 8'h00, 8'h00, 8'h00};
        send_frame(32'd5, 1'b0);
        // extended length with size-of-size five
        frame_q = {idf_pkg::MARKER, 8'hFF, 8'hFF, 8'h80, 8'h05};
        send_frame(32'd5, 1'b0);
        // header cut by buffer end, then one byte past the end
        frame_q = {idf_pkg::MARKER, 8'h03, 8'h04, 8'h12, idf_pkg::MARKER};
        send_frame(32'd4, 1'b0);

        random_items = 0;
        buffers      = 0;
        while (random_items < 900)
        begin
            random_items += add_buffer(buffers % 12 == 0);
            buffers++;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Checked at the falling edge, where every handshake signal is settled;
        // the run ends when the settle count runs down with nothing left to feed or due.
        settle = 8;
        while (settle != 0 && idle_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((data_valid && !data_stall) || (rslt_valid && !rslt_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (byte_feed.size() == 0 && !data_valid && due_results.size() == 0)
                settle--;
            else
                settle = 8;
        end

        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("iptc_dataset_deframer_core test failed");
        end
        else
        begin
            $display("%0d bytes in %0d random buffers plus directed cases; %0d results checked",
                     n_bytes, buffers, n_checked);
            $display("payload %0d, empty %0d, overrun %0d, bad size-of-size %0d",
                     kind_seen[idf_pkg::KIND_PAYLOAD], kind_seen[idf_pkg::KIND_EMPTY],
                     kind_seen[idf_pkg::KIND_OVERRUN], kind_seen[idf_pkg::KIND_BAD_SOS]);
            if (mismatches == 0)
                $display("iptc_dataset_deframer_core test passed");
            else
                $display("iptc_dataset_deframer_core test failed");
        end
        $finish;
    end

endmodule

[iptc_dataset_deframer_core.f]
sv/idf_pkg.sv
sv/idf_step.sv
sv/iptc_dataset_deframer_core.sv
sv/idf_checker.sv
tb/tb_iptc_dataset_deframer_core.sv
